// ===== rtl/ecc_pkg.sv =====
// Shared types and constants for the EVSE charge controller.
package ecc_pkg;

	// Field widths
	localparam int unsigned CMD_W      = 3;
	localparam int unsigned VEH_W      = 2;
	localparam int unsigned AMPS_W     = 12;
	localparam int unsigned CUR_W      = 10;
	localparam int unsigned MS_W       = 32;
	localparam int unsigned STATUS_W   = 2;
	localparam int unsigned APB_ADDR_W = 4;
	localparam int unsigned APB_DATA_W = 32;

	// Commands carried by a request transaction
	typedef enum logic [CMD_W-1:0] {
		CMD_POLL      = 3'd0,
		CMD_TICK      = 3'd1,
		CMD_START     = 3'd2,
		CMD_STOP      = 3'd3,
		CMD_SET_LIMIT = 3'd4
	} cmd_t;

	// Vehicle states sampled from the pilot
	localparam logic [VEH_W-1:0] VEH_NOT_CONNECTED = 2'd0;
	localparam logic [VEH_W-1:0] VEH_CONNECTED     = 2'd1;
	localparam logic [VEH_W-1:0] VEH_READY         = 2'd2;
	localparam logic [VEH_W-1:0] VEH_OTHER         = 2'd3;

	// Status codes
	localparam logic [STATUS_W-1:0] STATUS_OK               = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_ALREADY_CHARGING = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_NOT_READY        = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_NOT_CHARGING     = 2'd3;

	// Register indexes (word address)
	localparam logic [1:0] REG_MAX_CURRENT      = 2'd0;
	localparam logic [1:0] REG_FALLBACK_CURRENT = 2'd1;
	localparam logic [1:0] REG_LIMIT_TIMEOUT    = 2'd2;
	localparam logic [1:0] REG_MIN_ADVERTISE    = 2'd3;

	// Reset values
	localparam logic [CUR_W-1:0] RST_MAX_CURRENT      = 10'd320;
	localparam logic [CUR_W-1:0] RST_FALLBACK_CURRENT = 10'd60;
	localparam logic [MS_W-1:0]  RST_LIMIT_TIMEOUT    = 32'd0;
	localparam logic [CUR_W-1:0] RST_MIN_ADVERTISE    = 10'd60;

	// Configuration seen by the datapath
	typedef struct packed {
		logic [CUR_W-1:0] max_current;
		logic [CUR_W-1:0] fallback_current;
		logic [MS_W-1:0]  limit_timeout_ms;
		logic [CUR_W-1:0] min_advertise_current;
	} cfg_t;

endpackage

// ===== rtl/ecc_if.sv =====
// Request and result channel interfaces of the EVSE charge controller.
interface ecc_req_if import ecc_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [CMD_W-1:0]         command;
	logic [VEH_W-1:0]         vehicle_sample;
	logic signed [AMPS_W-1:0] amps_request;

	modport source (output valid, command, vehicle_sample, amps_request, input ready);
	modport sink   (input valid, command, vehicle_sample, amps_request, output ready);
endinterface

interface ecc_res_if import ecc_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                relay_closed;
	logic                charging;
	logic [VEH_W-1:0]    vehicle_now;
	logic                pilot_standby;
	logic [CUR_W-1:0]    advertised_current;
	logic [CUR_W-1:0]    limit_now;
	logic [MS_W-1:0]     elapsed_ms;
	logic [STATUS_W-1:0] status_code;
	logic                charge_state_changed;
	logic                vehicle_state_changed;

	modport source (
		output valid, relay_closed, charging, vehicle_now, pilot_standby,
		       advertised_current, limit_now, elapsed_ms, status_code,
		       charge_state_changed, vehicle_state_changed,
		input  ready
	);
	modport sink (
		input  valid, relay_closed, charging, vehicle_now, pilot_standby,
		       advertised_current, limit_now, elapsed_ms, status_code,
		       charge_state_changed, vehicle_state_changed,
		output ready
	);
endinterface

// ===== rtl/evse_charge_controller.sv =====
// Top level of the EVSE charge controller: request pipeline, state and result register.
//
// Usage:
//   request: one command per transaction (poll with a vehicle sample, 1 ms tick,
//     start, stop, or set limit with a signed request in tenths of an ampere).
//   result: exactly one transaction per request, carrying the relay, charging,
//     vehicle and pilot state, advertised current, limit, elapsed time since the
//     last start and a status code, all as they stand after the command.
//   APB: four registers at byte addresses 0, 4, 8, 12 (max current, fallback
//     current, limit timeout in ms, minimum advertised current); pready is always
//     high. Write them only while no request is in flight.
// A request lands in the input register when accepted, and the update logic loads
// the result register from it once that register is free or draining.
// Throughput is one request per cycle while the receiver takes results; the update
// logic writes the state registers as it loads the result register, so consecutive
// commands see each other.
// Reset clears the state to vehicle not connected, not charging, relay open,
// pilot in standby, limit 32.0 A and the millisecond clock at zero.
// When the receiver stalls, the result register holds, then the input register
// fills, and request.ready drops until the result is taken.
module evse_charge_controller import ecc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	ecc_req_if.sink               request,
	ecc_res_if.source             result
);

	cfg_t cfg;

	// Input register
	logic                     valid_s1;
	logic [CMD_W-1:0]         cmd_s1;
	logic [VEH_W-1:0]         sample_s1;
	logic signed [AMPS_W-1:0] amps_s1;

	// Controller state
	logic             vehicle_q;
	logic [VEH_W-1:0] vehicle_state_q;
	logic             charging_q;
	logic [CUR_W-1:0] limit_q;
	logic             relay_q;
	logic             standby_q;
	logic [CUR_W-1:0] advertised_q;
	logic [MS_W-1:0]  clock_q;
	logic [MS_W-1:0]  limit_upd_q;
	logic [MS_W-1:0]  started_q;

	// Next state
	logic [VEH_W-1:0]    vehicle_n;
	logic                charging_n;
	logic [CUR_W-1:0]    limit_n;
	logic                relay_n;
	logic                standby_n;
	logic [CUR_W-1:0]    advertised_n;
	logic [MS_W-1:0]     clock_n;
	logic [MS_W-1:0]     limit_upd_n;
	logic [MS_W-1:0]     started_n;
	logic [STATUS_W-1:0] status_n;
	logic                cs_chg_n;
	logic                vs_chg_n;

	// Limit update path
	logic             apply_en;
	logic [CUR_W-1:0] apply_val;
	logic [CUR_W-1:0] fallback_clamped;
	logic [CUR_W-1:0] request_clamped;
	logic [MS_W-1:0]  limit_age;
	logic             limit_stale;
	logic             sample_plugged;
	logic             next_plugged;

	// Result register
	logic                out_valid_q;
	logic                out_relay_q;
	logic                out_charging_q;
	logic [VEH_W-1:0]    out_vehicle_q;
	logic                out_standby_q;
	logic [CUR_W-1:0]    out_advertised_q;
	logic [CUR_W-1:0]    out_limit_q;
	logic [MS_W-1:0]     out_elapsed_q;
	logic [STATUS_W-1:0] out_status_q;
	logic                out_cs_chg_q;
	logic                out_vs_chg_q;

	logic advance;

	ecc_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Handshake: process the held item when the result register is free or draining
	assign advance       = valid_s1 & (~out_valid_q | result.ready);
	assign request.ready = ~valid_s1 | advance;

	// Capture the request transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (request.ready) begin
			valid_s1 <= request.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (request.ready && request.valid) begin
			cmd_s1    <= request.command;
			sample_s1 <= request.vehicle_sample;
			amps_s1   <= request.amps_request;
		end
	end

	// Clamp the fallback and request to the maximum; a negative request becomes zero
	assign fallback_clamped = (cfg.fallback_current > cfg.max_current) ?
	                          cfg.max_current : cfg.fallback_current;

	always_comb begin
		if (amps_s1[AMPS_W-1]) begin
			request_clamped = '0;
		end else if (amps_s1[AMPS_W-2:0] > {1'b0, cfg.max_current}) begin
			request_clamped = cfg.max_current;
		end else begin
			request_clamped = amps_s1[CUR_W-1:0];
		end
	end

	// Staleness of the current limit, modulo 2^32
	assign limit_age   = clock_q - limit_upd_q;
	assign limit_stale = (cfg.limit_timeout_ms != '0) &&
	                     (limit_age >= cfg.limit_timeout_ms) &&
	                     (limit_q > cfg.fallback_current);

	assign sample_plugged = (sample_s1 == VEH_CONNECTED) || (sample_s1 == VEH_READY);
	assign next_plugged   = (vehicle_n == VEH_CONNECTED) || (vehicle_n == VEH_READY);

	// Decode the command and compute the state before any limit update
	always_comb begin
		vehicle_n    = vehicle_state_q;
		charging_n   = charging_q;
		relay_n      = relay_q;
		standby_n    = standby_q;
		advertised_n = advertised_q;
		clock_n      = clock_q;
		started_n    = started_q;
		status_n     = STATUS_OK;
		cs_chg_n     = 1'b0;
		vs_chg_n     = 1'b0;
		apply_en     = 1'b0;
		apply_val    = request_clamped;
		unique case (cmd_s1)
			CMD_POLL: begin
				if (sample_s1 != vehicle_state_q) begin
					vehicle_n = sample_s1;
					vs_chg_n  = 1'b1;
					if (sample_plugged) begin
						advertised_n = limit_q;
						standby_n    = 1'b0;
					end else begin
						standby_n = 1'b1;
					end
				end
				if (sample_s1 != VEH_READY && charging_q) begin
					relay_n    = 1'b0;
					charging_n = 1'b0;
					cs_chg_n   = 1'b1;
				end
				apply_en  = limit_stale;
				apply_val = fallback_clamped;
			end
			CMD_TICK: begin
				clock_n = clock_q + 1'b1;
			end
			CMD_START: begin
				if (charging_q) begin
					status_n = STATUS_ALREADY_CHARGING;
				end else if (vehicle_state_q != VEH_READY) begin
					status_n = STATUS_NOT_READY;
				end else begin
					relay_n    = 1'b1;
					charging_n = 1'b1;
					started_n  = clock_q;
					cs_chg_n   = 1'b1;
				end
			end
			CMD_STOP: begin
				relay_n = 1'b0;
				if (!charging_q) begin
					status_n = STATUS_NOT_CHARGING;
				end else begin
					charging_n = 1'b0;
					cs_chg_n   = 1'b1;
				end
			end
			CMD_SET_LIMIT: begin
				apply_en = 1'b1;
			end
			default: ;
		endcase
	end

	// Apply and stamp a new limit; the state update advertises it to a plugged vehicle
	always_comb begin
		limit_n     = limit_q;
		limit_upd_n = limit_upd_q;
		if (apply_en) begin
			limit_n     = apply_val;
			limit_upd_n = clock_q;
		end
	end

	// Update the controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vehicle_state_q <= VEH_NOT_CONNECTED;
			charging_q      <= 1'b0;
			limit_q         <= RST_MAX_CURRENT;
			relay_q         <= 1'b0;
			standby_q       <= 1'b1;
			advertised_q    <= '0;
			clock_q         <= '0;
			limit_upd_q     <= '0;
			started_q       <= '0;
		end else if (advance) begin
			vehicle_state_q <= vehicle_n;
			charging_q      <= charging_n;
			limit_q         <= limit_n;
			clock_q         <= clock_n;
			limit_upd_q     <= limit_upd_n;
			started_q       <= started_n;
			if (apply_en && next_plugged) begin
				advertised_q <= apply_val;
				standby_q    <= 1'b0;
				relay_q      <= (apply_val >= cfg.min_advertise_current);
			end else begin
				advertised_q <= advertised_n;
				standby_q    <= standby_n;
				relay_q      <= relay_n;
			end
		end
	end

	assign vehicle_q = next_plugged;

	// Load the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_charging_q   <= charging_n;
			out_vehicle_q    <= vehicle_n;
			out_limit_q      <= limit_n;
			out_elapsed_q    <= clock_n - started_n;
			out_status_q     <= status_n;
			out_cs_chg_q     <= cs_chg_n;
			out_vs_chg_q     <= vs_chg_n;
			if (apply_en && vehicle_q) begin
				out_advertised_q <= apply_val;
				out_standby_q    <= 1'b0;
				out_relay_q      <= (apply_val >= cfg.min_advertise_current);
			end else begin
				out_advertised_q <= advertised_n;
				out_standby_q    <= standby_n;
				out_relay_q      <= relay_n;
			end
		end
	end

	assign result.valid                 = out_valid_q;
	assign result.relay_closed          = out_relay_q;
	assign result.charging              = out_charging_q;
	assign result.vehicle_now           = out_vehicle_q;
	assign result.pilot_standby         = out_standby_q;
	assign result.advertised_current    = out_advertised_q;
	assign result.limit_now             = out_limit_q;
	assign result.elapsed_ms            = out_elapsed_q;
	assign result.status_code           = out_status_q;
	assign result.charge_state_changed  = out_cs_chg_q;
	assign result.vehicle_state_changed = out_vs_chg_q;

	// Charging only ever runs with a ready vehicle
	assert property (@(posedge clk) disable iff (!arst_n)
		charging_q |-> (vehicle_state_q == VEH_READY))
		else $error("charging while vehicle not ready");

	// Pilot is in standby exactly when no vehicle is plugged in
	assert property (@(posedge clk) disable iff (!arst_n)
		standby_q == ~((vehicle_state_q == VEH_CONNECTED) ||
		               (vehicle_state_q == VEH_READY)))
		else $error("pilot standby out of step with vehicle state");

	// A tick advances the millisecond clock by one
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && cmd_s1 == CMD_TICK) |=> (clock_q == $past(clock_q) + 1'b1))
		else $error("tick did not advance the clock");

	// A rejected start or stop never reports a charging state change
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_status_q != STATUS_OK) |-> !out_cs_chg_q)
		else $error("state change reported with an error status");

endmodule

// ===== rtl/ecc_apb_regs.sv =====
// APB configuration register file of the EVSE charge controller.
module ecc_apb_regs import ecc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[3:2];
	assign cfg     = cfg_q;

	// Write a register at the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_current           <= RST_MAX_CURRENT;
			cfg_q.fallback_current      <= RST_FALLBACK_CURRENT;
			cfg_q.limit_timeout_ms      <= RST_LIMIT_TIMEOUT;
			cfg_q.min_advertise_current <= RST_MIN_ADVERTISE;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_MAX_CURRENT:      cfg_q.max_current <= pwdata[CUR_W-1:0];
				REG_FALLBACK_CURRENT: cfg_q.fallback_current <= pwdata[CUR_W-1:0];
				REG_LIMIT_TIMEOUT:    cfg_q.limit_timeout_ms <= pwdata[MS_W-1:0];
				REG_MIN_ADVERTISE:    cfg_q.min_advertise_current <= pwdata[CUR_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back the addressed register
	always_comb begin
		unique case (reg_idx)
			REG_MAX_CURRENT:
				prdata = {{(APB_DATA_W-CUR_W){1'b0}}, cfg_q.max_current};
			REG_FALLBACK_CURRENT:
				prdata = {{(APB_DATA_W-CUR_W){1'b0}}, cfg_q.fallback_current};
			REG_LIMIT_TIMEOUT:
				prdata = cfg_q.limit_timeout_ms;
			REG_MIN_ADVERTISE:
				prdata = {{(APB_DATA_W-CUR_W){1'b0}}, cfg_q.min_advertise_current};
			default:
				prdata = '0;
		endcase
	end

endmodule

// ===== dv/evse_charge_controller_tb.sv =====
// Self-checking testbench for the EVSE charge controller: directed table, random traffic, APB setup.
module evse_charge_controller_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ecc_pkg::*;

	// Command codes with no operation behind them
	localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
	localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

	localparam int CURRENT_TOP     = 800;
	localparam int RESET_CYCLES    = 5;
	localparam int LIMIT_CYCLES    = 400000;
	localparam int SEGMENTS        = 6;
	localparam int SEGMENT_ITEMS   = 292;
	localparam int SETTLE_CYCLES   = 8;
	localparam int MAX_REPORTS     = 10;

	typedef struct packed {
		logic                relay_closed;
		logic                charging;
		logic [VEH_W-1:0]    vehicle_now;
		logic                pilot_standby;
		logic [CUR_W-1:0]    advertised_current;
		logic [CUR_W-1:0]    limit_now;
		logic [MS_W-1:0]     elapsed_ms;
		logic [STATUS_W-1:0] status_code;
		logic                charge_state_changed;
		logic                vehicle_state_changed;
	} charge_res_t;

	typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

	typedef struct packed {
		row_kind_t                kind;
		logic [CMD_W-1:0]         cmd;
		logic [VEH_W-1:0]         sample;
		logic signed [AMPS_W-1:0] amps;
		logic [1:0]               reg_idx;
		logic [MS_W-1:0]          reg_val;
		logic                     typed;
		charge_res_t              want;
	} stim_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	ecc_req_if req_ch ();
	ecc_res_if res_ch ();

	evse_charge_controller dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.request (req_ch),
		.result  (res_ch)
	);

	// Expected results, oldest first
	charge_res_t expected_q[$];
	stim_row_t   stim_table[$];

	int src_idle_pct;
	int sink_idle_pct;
	int mismatch_count;
	int cycle_count;
	logic [VEH_W-1:0] wander_sample;

	// Controller state as the predictor sees it
	logic [VEH_W-1:0] veh_st;
	logic             charging_st;
	logic [CUR_W-1:0] limit_st;
	logic             relay_st;
	logic             standby_st;
	logic [CUR_W-1:0] adv_st;
	logic [MS_W-1:0]  ms_now;
	logic [MS_W-1:0]  limit_stamp;
	logic [MS_W-1:0]  start_stamp;

	// Register copies
	logic [CUR_W-1:0] cfg_max;
	logic [CUR_W-1:0] cfg_fallback;
	logic [MS_W-1:0]  cfg_timeout;
	logic [CUR_W-1:0] cfg_min_adv;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic void reset_model();
		cfg_max      = RST_MAX_CURRENT;
		cfg_fallback = RST_FALLBACK_CURRENT;
		cfg_timeout  = RST_LIMIT_TIMEOUT;
		cfg_min_adv  = RST_MIN_ADVERTISE;
		veh_st       = VEH_NOT_CONNECTED;
		charging_st  = 1'b0;
		limit_st     = RST_MAX_CURRENT;
		relay_st     = 1'b0;
		standby_st   = 1'b1;
		adv_st       = '0;
		ms_now       = '0;
		limit_stamp  = '0;
		start_stamp  = '0;
	endfunction

	function automatic logic vehicle_present();
		return veh_st == VEH_CONNECTED || veh_st == VEH_READY;
	endfunction

	// Clamp a requested limit, stamp it, and advertise it when a vehicle is present
	function automatic void store_limit(input int amps);
		logic [CUR_W-1:0] v;
		if (amps < 0) begin
			v = '0;
		end else if (amps > int'(cfg_max)) begin
			v = cfg_max;
		end else begin
			v = amps[CUR_W-1:0];
		end
		limit_st = v;
		limit_stamp = ms_now;
		if (vehicle_present()) begin
			adv_st = limit_st;
			standby_st = 1'b0;
			relay_st = (limit_st >= cfg_min_adv);
		end
	endfunction

	function automatic charge_res_t predict_charge(input logic [CMD_W-1:0] cmd,
	                                               input logic [VEH_W-1:0] sample,
	                                               input logic signed [AMPS_W-1:0] amps);
		charge_res_t r;
		logic [MS_W-1:0] age;
		r = '0;
		case (cmd)
			CMD_POLL: begin
				if (sample != veh_st) begin
					veh_st = sample;
					if (vehicle_present()) begin
						adv_st = limit_st;
						standby_st = 1'b0;
					end else begin
						standby_st = 1'b1;
					end
					r.vehicle_state_changed = 1'b1;
				end
				// drop the charge session when the vehicle is no longer ready
				if (veh_st != VEH_READY && charging_st) begin
					relay_st = 1'b0;
					charging_st = 1'b0;
					r.charge_state_changed = 1'b1;
				end
				// fall back to the safe current on a stale limit
				age = ms_now - limit_stamp;
				if (cfg_timeout != 0 && age >= cfg_timeout && limit_st > cfg_fallback)
					store_limit(int'(cfg_fallback));
			end
			CMD_TICK: ms_now = ms_now + 1;
			CMD_START: begin
				if (charging_st) begin
					r.status_code = STATUS_ALREADY_CHARGING;
				end else if (veh_st != VEH_READY) begin
					r.status_code = STATUS_NOT_READY;
				end else begin
					relay_st = 1'b1;
					charging_st = 1'b1;
					start_stamp = ms_now;
					r.charge_state_changed = 1'b1;
				end
			end
			CMD_STOP: begin
				relay_st = 1'b0;
				if (!charging_st) begin
					r.status_code = STATUS_NOT_CHARGING;
				end else begin
					charging_st = 1'b0;
					r.charge_state_changed = 1'b1;
				end
			end
			CMD_SET_LIMIT: store_limit(int'(amps));
			default: ;
		endcase
		r.relay_closed       = relay_st;
		r.charging           = charging_st;
		r.vehicle_now        = veh_st;
		r.pilot_standby      = standby_st;
		r.advertised_current = adv_st;
		r.limit_now          = limit_st;
		r.elapsed_ms         = ms_now - start_stamp;
		return r;
	endfunction

	function automatic charge_res_t mk_res(input logic relay, input logic chg,
	                                       input logic [VEH_W-1:0] veh, input logic stby,
	                                       input int adv, input int lim, input int elapsed,
	                                       input logic [STATUS_W-1:0] status,
	                                       input logic cs_chg, input logic vs_chg);
		mk_res = {relay, chg, veh, stby, adv[CUR_W-1:0], lim[CUR_W-1:0], elapsed[MS_W-1:0],
		          status, cs_chg, vs_chg};
	endfunction

	function automatic string res_text(input charge_res_t r);
		return $sformatf("relay=%0d chg=%0d veh=%0d stby=%0d adv=%0d lim=%0d el=%0d st=%0d cs=%0d vs=%0d",
		                 r.relay_closed, r.charging, r.vehicle_now, r.pilot_standby,
		                 r.advertised_current, r.limit_now, r.elapsed_ms, r.status_code,
		                 r.charge_state_changed, r.vehicle_state_changed);
	endfunction

	function automatic void stim_row(input logic [CMD_W-1:0] cmd, input logic [VEH_W-1:0] sample,
	                                 input int amps, input logic typed, input charge_res_t want);
		stim_row_t row;
		row = '0;
		row.kind = ROW_ITEM;
		row.cmd = cmd;
		row.sample = sample;
		row.amps = amps[AMPS_W-1:0];
		row.typed = typed;
		row.want = want;
		stim_table.push_back(row);
	endfunction

	function automatic void stim_reg(input logic [1:0] idx, input logic [MS_W-1:0] value);
		stim_row_t row;
		row = '0;
		row.kind = ROW_REG;
		row.reg_idx = idx;
		row.reg_val = value;
		stim_table.push_back(row);
	endfunction

	// Offer one request transaction after a random gap and log its expectation
	task automatic put_item(input logic [CMD_W-1:0] cmd, input logic [VEH_W-1:0] sample,
	                        input logic signed [AMPS_W-1:0] amps, input logic typed,
	                        input charge_res_t want);
		charge_res_t predicted;
		while ($urandom_range(0, 99) < src_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.command <= cmd;
		req_ch.vehicle_sample <= sample;
		req_ch.amps_request <= amps;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		predicted = predict_charge(cmd, sample, amps);
		expected_q.push_back(typed ? want : predicted);
	endtask

	// Hold the request channel idle until every result is back
	task automatic drain_results();
		if (req_ch.valid) req_ch.valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
	endtask

	// APB write: setup, access, then release the bus
	task automatic set_reg(input logic [1:0] idx, input logic [MS_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_MAX_CURRENT:      cfg_max = value[CUR_W-1:0];
			REG_FALLBACK_CURRENT: cfg_fallback = value[CUR_W-1:0];
			REG_LIMIT_TIMEOUT:    cfg_timeout = value;
			REG_MIN_ADVERTISE:    cfg_min_adv = value[CUR_W-1:0];
			default: ;
		endcase
	endtask

	function automatic logic [MS_W-1:0] pick_current();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return CURRENT_TOP;
			default: return $urandom_range(0, CURRENT_TOP);
		endcase
	endfunction

	function automatic logic [MS_W-1:0] pick_timeout();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return 1;
			2: return '1;
			3: return $urandom;
			default: return $urandom_range(2, 40);
		endcase
	endfunction

	// Mostly well-formed traffic: a sticky vehicle state, ticks, sessions and limits
	task automatic roll_item(output logic [CMD_W-1:0] cmd, output logic [VEH_W-1:0] sample,
	                         output logic signed [AMPS_W-1:0] amps);
		int pick;
		int a;
		pick = $urandom_range(0, 99);
		if (pick < 30) cmd = CMD_POLL;
		else if (pick < 58) cmd = CMD_TICK;
		else if (pick < 70) cmd = CMD_START;
		else if (pick < 79) cmd = CMD_STOP;
		else if (pick < 95) cmd = CMD_SET_LIMIT;
		else cmd = CMD_W'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
		if ($urandom_range(0, 9) == 0) wander_sample = VEH_W'($urandom_range(0, 3));
		sample = (cmd == CMD_POLL) ? wander_sample : VEH_W'($urandom_range(0, 3));
		case ($urandom_range(0, 4))
			0: a = $urandom_range(0, 4095);
			1: a = int'(cfg_min_adv) + int'($urandom_range(0, 8)) - 4;
			2: a = int'(cfg_max) + int'($urandom_range(0, 8)) - 4;
			default: a = $urandom_range(0, CURRENT_TOP);
		endcase
		amps = a[AMPS_W-1:0];
	endtask

	// Result sink: random stalls, compare each transaction with the oldest expectation
	always @(posedge clk) begin : result_check
		charge_res_t got;
		charge_res_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got = {res_ch.relay_closed, res_ch.charging, res_ch.vehicle_now,
			       res_ch.pilot_standby, res_ch.advertised_current, res_ch.limit_now,
			       res_ch.elapsed_ms, res_ch.status_code, res_ch.charge_state_changed,
			       res_ch.vehicle_state_changed};
			if (expected_q.size() == 0) begin
				mismatch_count = mismatch_count + 1;
				if (mismatch_count <= MAX_REPORTS)
					$display("cycle %0d: unexpected result %s", cycle_count, res_text(got));
			end else begin
				want = expected_q.pop_front();
				if (got.relay_closed !== want.relay_closed ||
				    got.charging !== want.charging ||
				    got.vehicle_now !== want.vehicle_now ||
				    got.pilot_standby !== want.pilot_standby ||
				    got.advertised_current !== want.advertised_current ||
				    got.limit_now !== want.limit_now ||
				    got.elapsed_ms !== want.elapsed_ms ||
				    got.status_code !== want.status_code ||
				    got.charge_state_changed !== want.charge_state_changed ||
				    got.vehicle_state_changed !== want.vehicle_state_changed) begin
					mismatch_count = mismatch_count + 1;
					if (mismatch_count <= MAX_REPORTS)
						$display("cycle %0d: mismatch\n  expected %s\n  actual   %s",
						         cycle_count, res_text(want), res_text(got));
				end
			end
		end
		res_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("evse_charge_controller verification failed");
			$finish;
		end
	end

	initial begin
		stim_row_t row;
		logic [CMD_W-1:0] cmd;
		logic [VEH_W-1:0] sample;
		logic signed [AMPS_W-1:0] amps;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_ch.valid = 1'b0;
		req_ch.command = CMD_POLL;
		req_ch.vehicle_sample = VEH_NOT_CONNECTED;
		req_ch.amps_request = '0;
		res_ch.ready = 1'b0;
		mismatch_count = 0;
		cycle_count = 0;
		wander_sample = VEH_READY;
		src_idle_pct = 29;
		sink_idle_pct = 76;
		reset_model();

		// Directed table: reset state, error codes, clamps, session flow, fallback
		stim_row(CMD_POLL, VEH_NOT_CONNECTED, 0, 1'b1,
		         mk_res(0, 0, VEH_NOT_CONNECTED, 1, 0, 320, 0, STATUS_OK, 0, 0));
		stim_row(CMD_START, VEH_READY, 0, 1'b1,
		         mk_res(0, 0, VEH_NOT_CONNECTED, 1, 0, 320, 0, STATUS_NOT_READY, 0, 0));
		stim_row(CMD_STOP, VEH_READY, 0, 1'b1,
		         mk_res(0, 0, VEH_NOT_CONNECTED, 1, 0, 320, 0, STATUS_NOT_CHARGING, 0, 0));
		stim_row(CMD_SET_LIMIT, VEH_OTHER, -2048, 1'b1,
		         mk_res(0, 0, VEH_NOT_CONNECTED, 1, 0, 0, 0, STATUS_OK, 0, 0));
		stim_row(CMD_SET_LIMIT, VEH_NOT_CONNECTED, 2047, 1'b1,
		         mk_res(0, 0, VEH_NOT_CONNECTED, 1, 0, 320, 0, STATUS_OK, 0, 0));
		stim_row(CMD_POLL, VEH_CONNECTED, 0, 1'b0, '0);
		stim_row(CMD_POLL, VEH_READY, 0, 1'b0, '0);
		stim_row(CMD_START, VEH_NOT_CONNECTED, 0, 1'b0, '0);
		stim_row(CMD_START, VEH_OTHER, -1, 1'b1,
		         mk_res(1, 1, VEH_READY, 0, 320, 320, 0, STATUS_ALREADY_CHARGING, 0, 0));
		stim_row(CMD_TICK, VEH_OTHER, -1, 1'b0, '0);
		stim_row(CMD_SET_LIMIT, VEH_READY, 50, 1'b0, '0);
		stim_row(CMD_SET_LIMIT, VEH_READY, 100, 1'b0, '0);
		stim_row(CMD_POLL, VEH_CONNECTED, 0, 1'b0, '0);
		stim_row(CMD_SPARE_LO, VEH_OTHER, 2047, 1'b0, '0);
		stim_row(CMD_SPARE_HI, VEH_OTHER, -2048, 1'b0, '0);
		stim_row(CMD_POLL, VEH_OTHER, 0, 1'b0, '0);
		stim_row(CMD_SET_LIMIT, VEH_OTHER, 200, 1'b0, '0);
		stim_row(CMD_POLL, VEH_NOT_CONNECTED, 0, 1'b0, '0);
		stim_reg(REG_MAX_CURRENT, CURRENT_TOP);
		stim_reg(REG_MIN_ADVERTISE, 0);
		stim_row(CMD_SET_LIMIT, VEH_NOT_CONNECTED, 2047, 1'b0, '0);
		stim_row(CMD_POLL, VEH_READY, 0, 1'b0, '0);
		// lower max below a fallback that must still be clamped
		stim_reg(REG_MAX_CURRENT, 100);
		stim_reg(REG_FALLBACK_CURRENT, 500);
		stim_reg(REG_LIMIT_TIMEOUT, 2);
		stim_row(CMD_TICK, VEH_READY, 0, 1'b0, '0);
		stim_row(CMD_TICK, VEH_READY, 0, 1'b0, '0);
		stim_row(CMD_POLL, VEH_READY, 0, 1'b0, '0);
		stim_row(CMD_START, VEH_READY, 0, 1'b0, '0);
		stim_reg(REG_LIMIT_TIMEOUT, '1);
		stim_reg(REG_MIN_ADVERTISE, CURRENT_TOP);
		stim_reg(REG_FALLBACK_CURRENT, 0);
		stim_row(CMD_SET_LIMIT, VEH_READY, 799, 1'b0, '0);
		stim_row(CMD_STOP, VEH_READY, 0, 1'b0, '0);

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		foreach (stim_table[i]) begin
			row = stim_table[i];
			if (row.kind == ROW_REG) begin
				drain_results();
				set_reg(row.reg_idx, row.reg_val);
			end else begin
				put_item(row.cmd, row.sample, row.amps, row.typed, row.want);
			end
		end

		// Random segments, each with fresh register settings; each pair of segments shares an idle mix
		for (int seg = 0; seg < SEGMENTS; seg++) begin
			case (seg / 2)
				0: begin
					src_idle_pct = 29;
					sink_idle_pct = 76;
				end
				1: begin
					src_idle_pct = 76;
					sink_idle_pct = 29;
				end
				default: begin
					src_idle_pct = 0;
					sink_idle_pct = 0;
				end
			endcase
			drain_results();
			set_reg(REG_MAX_CURRENT, pick_current());
			set_reg(REG_FALLBACK_CURRENT, pick_current());
			set_reg(REG_LIMIT_TIMEOUT, pick_timeout());
			set_reg(REG_MIN_ADVERTISE, pick_current());
			for (int n = 0; n < SEGMENT_ITEMS; n++) begin
				roll_item(cmd, sample, amps);
				put_item(cmd, sample, amps, 1'b0, '0);
				if ($urandom_range(0, 149) == 0) drain_results();
			end
		end

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_q.size() == 0) begin
			$display("evse_charge_controller verification clean");
		end else begin
			$display("evse_charge_controller verification failed");
		end
		$finish;
	end

endmodule
